// ===== src/spl_pkg.sv =====
// Shared types and constants for the slot pool with lifetime aging.
package spl_pkg;

   localparam int COORD_W  = 32;
   localparam int LIFE_W   = 16;
   localparam int STATUS_W = 2;

   localparam logic OP_SPAWN = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_STORED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TICK   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RSVD   = 2'd3;

   localparam logic [LIFE_W-1:0] LIFE_ONE = 16'd1;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] vel_x;
      logic [COORD_W-1:0] vel_y;
      logic [LIFE_W-1:0]  life;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

// ===== src/spl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module spl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/slot_pool_with_lifetime_aging_top.sv =====
// Top level of the slot pool with lifetime aging.
//
// Request channel (req_*): opcode 0 spawns an entry into the lowest free
// slot using the position, velocity and lifetime fields; opcode 1 runs one
// tick over the whole pool. Every request yields exactly one response item
// on rsp_status: 0 stored, 1 pool full, 2 tick done.
// All slot state lives in RAM and is visited through one read port and one
// write port. A spawn scans the active flags one slot a cycle and raises
// rsp_valid once it finds the first free slot or has checked the last one.
// A tick visits each slot x then y through one shared 32-bit adder. One
// request is in work at a time; req_ready is high only while the sequencer
// is idle, which starts in the cycle the response is raised. After reset a
// clearing pass zeroes the active flags, and req_ready stays low until it
// ends. A stalled response is held in the output register; the next
// request is accepted meanwhile and its response waits until the register
// frees.
module slot_pool_with_lifetime_aging_top #(
   parameter int SLOTS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic signed [spl_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [spl_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [spl_pkg::COORD_W-1:0]   req_vel_x,
   input  logic signed [spl_pkg::COORD_W-1:0]   req_vel_y,
   input  logic        [spl_pkg::LIFE_W-1:0]    req_life_ticks,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [spl_pkg::STATUS_W-1:0]  rsp_status
);
   import spl_pkg::*;

   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(SLOTS - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SPAWN  = 3'd2;
   localparam logic [2:0] ST_TICK_X = 3'd3;
   localparam logic [2:0] ST_TICK_Y = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   slot_type            spawn_ff, spawn_in;
   logic [COORD_W-1:0]  sum_x_ff, sum_x_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic                act_we;
   logic [0:0]          act_wd;
   logic [0:0]          act_rd;
   logic                data_we;
   slot_type            data_wd;
   slot_type            slot_rd;
   logic [COORD_W-1:0]  add_a;
   logic [COORD_W-1:0]  add_b;
   logic [COORD_W-1:0]  add_sum;

   spl_ram #(
      .WIDTH (1),
      .DEPTH (SLOTS)
   ) u_active_ram (
      .clock   (clock),
      .wr_en   (act_we),
      .wr_addr (wr_addr),
      .wr_data (act_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (act_rd)
   );

   spl_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (wr_addr),
      .wr_data (data_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (slot_rd)
   );

   assign add_sum = add_a + add_b;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      spawn_in      = spawn_ff;
      sum_x_in      = sum_x_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_addr       = idx_ff;
      act_we        = 1'b0;
      act_wd        = 1'b0;
      data_we       = 1'b0;
      data_wd       = slot_rd;
      add_a         = slot_rd.pos_x;
      add_b         = slot_rd.vel_x;
      req_ready     = (state_ff == ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            act_we = 1'b1;
            if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               rd_en          = 1'b1;
               rd_addr        = '0;
               idx_in         = '0;
               spawn_in.pos_x = req_pos_x;
               spawn_in.pos_y = req_pos_y;
               spawn_in.vel_x = req_vel_x;
               spawn_in.vel_y = req_vel_y;
               spawn_in.life  = req_life_ticks;
               state_in       = (req_opcode == OP_TICK) ? ST_TICK_X : ST_SPAWN;
            end
         end
         ST_SPAWN: begin
            if (!act_rd[0]) begin
               act_we    = 1'b1;
               act_wd    = 1'b1;
               data_we   = 1'b1;
               data_wd   = spawn_ff;
               status_in = STATUS_STORED;
               state_in  = ST_DONE;
            end else if (idx_ff == LAST) begin
               status_in = STATUS_FULL;
               state_in  = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_TICK_X: begin
            sum_x_in = add_sum;
            state_in = ST_TICK_Y;
         end
         ST_TICK_Y: begin
            add_a         = slot_rd.pos_y;
            add_b         = slot_rd.vel_y;
            data_wd.pos_x = sum_x_ff;
            data_wd.pos_y = add_sum;
            data_wd.life  = slot_rd.life - LIFE_ONE;
            data_we       = act_rd[0];
            // expiring slot: drop its active flag
            if (act_rd[0] && (slot_rd.life <= LIFE_ONE)) begin
               act_we = 1'b1;
            end
            if (idx_ff == LAST) begin
               status_in = STATUS_TICK;
               state_in  = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TICK_X;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            idx_in   = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      spawn_ff      <= spawn_in;
      sum_x_ff      <= sum_x_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a request is in work");

   a_set_only_on_spawn: assert property (@(posedge clock) disable iff (reset)
      act_we && act_wd[0] |-> state_ff == ST_SPAWN)
      else $error("active flag set outside a spawn");

   a_no_port_collision: assert property (@(posedge clock) disable iff (reset)
      rd_en && (data_we || act_we) |-> rd_addr != wr_addr)
      else $error("read and write hit the same slot in one cycle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != STATUS_RSVD)
      else $error("response carries an unused status code");

endmodule

// ===== tb/tb_slot_pool_with_lifetime_aging_top.sv =====
// Testbench for the slot pool: directed table plus random traffic checked by a predictor.
`timescale 1ns / 100ps

module tb_slot_pool_with_lifetime_aging_top;
   import spl_pkg::*;

   localparam int SLOTS = 256;
   localparam int DIR_ROWS = 16;

   typedef struct packed {
      logic                op;
      logic [COORD_W-1:0]  px;
      logic [COORD_W-1:0]  py;
      logic [COORD_W-1:0]  vx;
      logic [COORD_W-1:0]  vy;
      logic [LIFE_W-1:0]   life;
      logic                pinned;
      logic [STATUS_W-1:0] want;
   } pool_req_type;

   // op, pos_x, pos_y, vel_x, vel_y, life, pinned, status
   localparam pool_req_type DIR_TBL [DIR_ROWS] = '{
      '{OP_TICK,  32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, STATUS_TICK},
      '{OP_SPAWN, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'h0000,
        1'b1, STATUS_STORED},
      '{OP_TICK,  32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff,
        1'b1, STATUS_TICK},
      '{OP_SPAWN, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h0001,
        1'b1, STATUS_STORED},
      '{OP_SPAWN, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff,
        1'b1, STATUS_STORED},
      '{OP_SPAWN, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0002, 1'b1, STATUS_STORED},
      '{OP_SPAWN, 32'h00010000, 32'hfffe0000, 32'h00008000, 32'hffff8000, 16'h0003,
        1'b0, STATUS_STORED},
      '{OP_TICK,  32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 16'haaaa,
        1'b1, STATUS_TICK},
      '{OP_SPAWN, 32'h12345678, 32'h87654321, 32'h0000ffff, 32'hffff0001, 16'h0000,
        1'b0, STATUS_STORED},
      '{OP_TICK,  32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, STATUS_TICK},
      '{OP_SPAWN, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 16'h5555,
        1'b0, STATUS_STORED},
      '{OP_SPAWN, 32'h0, 32'h0, 32'h00000001, 32'hffffffff, 16'h8000,
        1'b0, STATUS_STORED},
      '{OP_TICK,  32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, STATUS_TICK},
      '{OP_TICK,  32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, STATUS_TICK},
      '{OP_SPAWN, 32'h7fff0000, 32'h80010000, 32'h7fffffff, 32'h7fffffff, 16'h7fff,
        1'b0, STATUS_STORED},
      '{OP_TICK,  32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0, STATUS_TICK}
   };

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_opcode = OP_SPAWN;
   logic signed [COORD_W-1:0]  req_pos_x = '0;
   logic signed [COORD_W-1:0]  req_pos_y = '0;
   logic signed [COORD_W-1:0]  req_vel_x = '0;
   logic signed [COORD_W-1:0]  req_vel_y = '0;
   logic        [LIFE_W-1:0]   req_life_ticks = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic        [STATUS_W-1:0] rsp_status;

   slot_pool_with_lifetime_aging_top #(.SLOTS(SLOTS)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_life_ticks(req_life_ticks),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status)
   );

   // predicted pool contents
   bit                 act_tbl  [SLOTS];
   logic [COORD_W-1:0] px_tbl   [SLOTS];
   logic [COORD_W-1:0] py_tbl   [SLOTS];
   logic [COORD_W-1:0] vx_tbl   [SLOTS];
   logic [COORD_W-1:0] vy_tbl   [SLOTS];
   logic [LIFE_W-1:0]  life_tbl [SLOTS];
   int                 act_cnt = 0;

   logic [STATUS_W-1:0] status_q [$];
   pool_req_type        pin_q [$];
   int                  err_cnt = 0;
   int                  burst_left = 0;
   int                  stall_left = 0;
   int unsigned         rx_cycle = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_slot_pool_with_lifetime_aging_top: FAIL");
      $finish;
   end

   function automatic logic [STATUS_W-1:0] pool_step(input logic op,
         input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
         input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
         input logic [LIFE_W-1:0] life);
      int k;
      if (op == OP_SPAWN) begin
         for (k = 0; k < SLOTS; k++) begin
            if (!act_tbl[k]) begin
               px_tbl[k]   = px;
               py_tbl[k]   = py;
               vx_tbl[k]   = vx;
               vy_tbl[k]   = vy;
               life_tbl[k] = life;
               act_tbl[k]  = 1'b1;
               act_cnt++;
               return STATUS_STORED;
            end
         end
         return STATUS_FULL;
      end
      for (k = 0; k < SLOTS; k++) begin
         if (act_tbl[k]) begin
            px_tbl[k] = px_tbl[k] + vx_tbl[k];
            py_tbl[k] = py_tbl[k] + vy_tbl[k];
            if (life_tbl[k] <= LIFE_ONE) begin
               life_tbl[k] = '0;
               act_tbl[k]  = 1'b0;
               act_cnt--;
            end else begin
               life_tbl[k] = life_tbl[k] - LIFE_ONE;
            end
         end
      end
      return STATUS_TICK;
   endfunction

   function automatic pool_req_type mk_req(input logic op, input logic [LIFE_W-1:0] life);
      pool_req_type r;
      r.op     = op;
      r.px     = $urandom;
      r.py     = $urandom;
      r.vx     = $urandom;
      r.vy     = $urandom;
      r.life   = life;
      r.pinned = 1'b0;
      r.want   = STATUS_STORED;
      return r;
   endfunction

   task automatic drive_req(input pool_req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 15);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      pin_q.push_back(r);
      req_valid      <= 1'b1;
      req_opcode     <= r.op;
      req_pos_x      <= r.px;
      req_pos_y      <= r.py;
      req_vel_x      <= r.vx;
      req_vel_y      <= r.vy;
      req_life_ticks <= r.life;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_mix(input int n);
      int i;
      int sel;
      logic [LIFE_W-1:0] life;
      for (i = 0; i < n; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 3) begin
            drive_req(mk_req(OP_TICK, LIFE_W'($urandom)));
         end else begin
            sel = $urandom_range(0, 9);
            if (sel < 5) life = LIFE_W'($urandom_range(0, 4));
            else if (sel < 8) life = LIFE_W'($urandom_range(0, 40));
            else life = LIFE_W'($urandom);
            drive_req(mk_req(OP_SPAWN, life));
         end
      end
   endtask

   // receiver: quiet stretches alternate with bursty stalls, some of them long
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         rx_cycle   <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (rx_cycle[11] && $urandom_range(0, 7) == 0) begin
               if ($urandom_range(0, 31) == 0) stall_left <= $urandom_range(300, 700);
               else stall_left <= $urandom_range(1, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      pool_req_type        pin;
      logic [STATUS_W-1:0] got;
      logic [STATUS_W-1:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $error("status: expected none, actual %0d", rsp_status);
               err_cnt++;
            end else begin
               want = status_q.pop_front();
               if (rsp_status !== want) begin
                  $error("status: expected %0d, actual %0d", want, rsp_status);
                  err_cnt++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pin = pin_q.pop_front();
            got = pool_step(req_opcode, req_pos_x, req_pos_y, req_vel_x, req_vel_y,
                            req_life_ticks);
            status_q.push_back(pin.pinned ? pin.want : got);
         end
      end
   end

   initial begin
      int i;
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIR_ROWS; i++) drive_req(DIR_TBL[i]);
      wait_drained();

      run_mix(40);
      wait_drained();

      // fill the pool, then overflow it
      n = SLOTS - act_cnt;
      repeat (n) drive_req(mk_req(OP_SPAWN, LIFE_W'($urandom_range(0, 6))));
      repeat (6) drive_req(mk_req(OP_SPAWN, LIFE_W'($urandom)));
      wait_drained();

      drive_req(mk_req(OP_TICK, LIFE_W'($urandom)));
      wait_drained();
      n = SLOTS - act_cnt;
      repeat (n + 2) drive_req(mk_req(OP_SPAWN, LIFE_W'($urandom_range(0, 6))));

      repeat (8) drive_req(mk_req(OP_TICK, LIFE_W'($urandom)));
      run_mix(40);

      wait_drained();
      repeat (2 * SLOTS + 16) @(posedge clock);
      if (err_cnt == 0 && status_q.size() == 0) begin
         $display("tb_slot_pool_with_lifetime_aging_top: PASS");
      end else begin
         $display("tb_slot_pool_with_lifetime_aging_top: FAIL");
      end
      $finish;
   end

endmodule
